// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre |-> post in the same cycle
`define ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// pre |=> post in the next cycle
`define ASSERT_NXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/sm4_pkg.sv
// ----------------------------------------------------------------------------
// SM4 encrypt core package
// Transfer types, op codes, S-box and linear transform helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sm4_pkg;

	localparam int ROUNDS = 32;
	localparam int RK_AW  = $clog2(ROUNDS);

	localparam logic OP_KEY = 1'b0;
	localparam logic OP_ENC = 1'b1;

	localparam int ROT_A = 2;
	localparam int ROT_B = 10;
	localparam int ROT_C = 18;
	localparam int ROT_D = 24;

	typedef struct packed {
		logic        op;
		logic [4:0]  key_index;
		logic [31:0] key_word;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} sm4_in_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} sm4_out_t;

	typedef struct packed {
		logic [31:0] x0;
		logic [31:0] x1;
		logic [31:0] x2;
		logic [31:0] x3;
	} sm4_state_t;

	// byte i of the S-box sits at bits [2047-8*i -: 8]
	localparam logic [2047:0] SBOX_FLAT = {
		128'hd690e9fe_cce13db7_16b614c2_28fb2c05,
		128'h2b679a76_2abe04c3_aa441326_49860699,
		128'h9c4250f4_91ef987a_33540b43_edcfac62,
		128'he4b31ca9_c908e895_80df94fa_758f3fa6,
		128'h4707a7fc_f37317ba_83593c19_e6854fa8,
		128'h686b81b2_7164da8b_f8eb0f4b_70569d35,
		128'h1e240e5e_6358d1a2_25227c3b_01217887,
		128'hd4004657_9fd32752_4c3602e7_a0c4c89e,
		128'heabf8ad2_40c738b5_a3f7f2ce_f96115a1,
		128'he0ae5da4_9b341a55_ad933230_f58cb1e3,
		128'h1df6e22e_8266ca60_c02923ab_0d534e6f,
		128'hd5db3745_defd8e2f_03ff6a72_6d6c5b51,
		128'h8d1baf92_bbddbc7f_11d95c41_1f105ad8,
		128'h0ac13188_a5cd7bbd_2d74d012_b8e5b4b0,
		128'h8969974a_0c96777e_65b9f109_c56ec684,
		128'h18f07dec_3adc4d20_79ee5f3e_d7cb3948
	};

	function automatic logic [7:0] sbox(input logic [7:0] a);
		return SBOX_FLAT[2047 - 8 * int'(a) -: 8];
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] lin(input logic [31:0] b);
		return b ^ rotl(b, ROT_A) ^ rotl(b, ROT_B) ^ rotl(b, ROT_C) ^ rotl(b, ROT_D);
	endfunction

endpackage

`default_nettype wire

// File: rtl/sm4_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/sm4_round.sv
// ----------------------------------------------------------------------------
// SM4 round unit
// One round: x0 ^ L(S(x1 ^ x2 ^ x3 ^ rk)).
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_round import sm4_pkg::*; (
	input  wire sm4_state_t  cur,
	input  wire logic [31:0] rk,
	output logic      [31:0] nxt
);

	logic [31:0] mix;
	logic [31:0] sub;

	always_comb begin
		mix = cur.x1 ^ cur.x2 ^ cur.x3 ^ rk;
		for (int i = 0; i < 4; i++) begin
			sub[8*i +: 8] = sbox(mix[8*i +: 8]);
		end
		nxt = cur.x0 ^ lin(sub);
	end

endmodule

`default_nettype wire

// File: rtl/sm4_block_encrypt_core.sv
// ----------------------------------------------------------------------------
// SM4 block encrypt core
// Iterative SM4 encryption, one round per cycle, round keys in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers on a rising edge with start high and busy low.
//   item.op = OP_KEY stores item.key_word as round key item.key_index; it
//   keeps busy low and gives no result.
//   item.op = OP_ENC encrypts {block_high, block_low}. busy stays high for
//   all rounds, one round per cycle through the shared round unit, the round
//   key for the next round being read from the key RAM meanwhile.
//   done rises as the last round ends and pulses for one cycle with the
//   ciphertext on result; the next item may start in that same cycle, since
//   busy is low again.
//   All 32 round keys must be written before the first encryption.
//   Reset clears the sequencer and strobe; the key RAM is not cleared.
//   The receiver cannot stall: result is valid only while done is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sm4_block_encrypt_core import sm4_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire sm4_in_t  item,
	output logic          busy,
	output logic          done,
	output sm4_out_t      result
);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	localparam logic [RK_AW-1:0] LAST = RK_AW'(ROUNDS - 1);

	state_t             state_q;
	logic [RK_AW-1:0]   round_q;
	sm4_state_t         words_q;
	logic               done_q;
	sm4_out_t           result_q;

	logic               accept;
	logic               key_we;
	logic [RK_AW-1:0]   rk_raddr;
	logic [31:0]        rk;
	logic [31:0]        nxt;

	assign busy   = (state_q == ST_RUN);
	assign accept = start && !busy;
	assign key_we = accept && (item.op == OP_KEY);
	assign rk_raddr = busy ? RK_AW'(round_q + 1'b1) : '0;
	assign done   = done_q;
	assign result = result_q;

	sm4_ram #(
		.WIDTH(32),
		.DEPTH(ROUNDS)
	) u_rk_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (item.key_index[RK_AW-1:0]),
		.wdata (item.key_word),
		.raddr (rk_raddr),
		.rdata (rk)
	);

	sm4_round u_round (
		.cur (words_q),
		.rk  (rk),
		.nxt (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			round_q  <= '0;
			done_q   <= 1'b0;
			words_q  <= '0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (item.op == OP_ENC)) begin
						words_q <= {item.block_high, item.block_low};
						round_q <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					words_q <= {words_q.x1, words_q.x2, words_q.x3, nxt};
					round_q <= RK_AW'(round_q + 1'b1);
					if (round_q == LAST) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						result_q <= {nxt, words_q.x3, words_q.x2, words_q.x1};
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_NXT(a_enc_starts_run, accept && (item.op == OP_ENC),
		busy && (round_q == '0), "encrypt transfer did not start round 0")
	`ASSERT_NXT(a_key_stays_idle, accept && (item.op == OP_KEY),
		!busy && !done, "key write started a run or a result")
	`ASSERT_NXT(a_last_round_done, busy && (round_q == LAST),
		done && !busy, "last round did not finish the block")
	`ASSERT_IMP(a_done_after_run, done,
		!busy && $past(busy), "result strobe without a finished run")

endmodule

`default_nettype wire
